// ===== hdl/emf_rsv_pkg.sv =====
// ----------------------------------------------------------------------------
// emf_rsv_pkg
// Shared types and constants of the metafile record stream validator.
// ----------------------------------------------------------------------------
package emf_rsv_pkg;

    localparam int LENGTH_BITS = 40;
    localparam int WORD_BITS   = LENGTH_BITS - 2;
    localparam int BYTES_BITS  = 40;

    localparam logic [31:0] EMF_SIGNATURE = 32'h464D_4520;
    localparam logic [31:0] HDR_MIN_SIZE  = 32'h0000_0034;
    localparam logic [31:0] HDR_MAGIC     = 32'h0000_0001;
    localparam logic [31:0] EOF_TYPE      = 32'd14;
    localparam logic [31:0] MIN_REC_SIZE  = 32'd8;

    localparam logic [31:0] MAX_RECORD_RESET = 32'd1048576;
    localparam logic [31:0] MIN_TOTAL_RESET  = 32'd88;

    // fixed header word positions
    localparam logic [WORD_BITS-1:0] POS_MAGIC     = WORD_BITS'(0);
    localparam logic [WORD_BITS-1:0] POS_HDR_SIZE  = WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] POS_WALK      = WORD_BITS'(2);
    localparam logic [WORD_BITS-1:0] POS_SIGNATURE = WORD_BITS'(10);
    localparam logic [WORD_BITS-1:0] POS_TOTAL     = WORD_BITS'(12);
    localparam logic [WORD_BITS-1:0] POS_RESERVED  = WORD_BITS'(14);

    localparam logic [WORD_BITS-1:0]  WORD_MASK = {WORD_BITS{1'b1}};
    localparam logic [BYTES_BITS-1:0] LEN_MASK  = BYTES_BITS'({LENGTH_BITS{1'b1}});

    typedef enum logic [2:0] {
        ST_CONTINUE   = 3'd0,
        ST_COMPLETE   = 3'd1,
        ST_BAD_RECORD = 3'd2,
        ST_REJECTED   = 3'd3,
        ST_INACTIVE   = 3'd4
    } t_status;

    typedef enum logic {
        REG_MAX_RECORD = 1'b0,
        REG_MIN_TOTAL  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic                 active;
        logic [WORD_BITS-1:0] word_pos;
        logic [WORD_BITS-1:0] next_rec;
        logic                 pend_end;
        logic                 hdr_ok;
    } t_walk_state;

    typedef struct packed {
        logic                  record_start;
        t_status               status;
        logic [BYTES_BITS-1:0] file_bytes;
    } t_result;

endpackage

// ===== hdl/emf_record_stream_validator.sv =====
// ----------------------------------------------------------------------------
// emf_record_stream_validator
// Header check and record walk over a candidate metafile word stream.
// ----------------------------------------------------------------------------
// Input channel: one little-endian 32-bit file word per item on i_s_tdata,
// with i_s_tuser set on word 0 of a new candidate file. Output channel: one
// item per input item, carrying status and record_start on o_m_tuser and the
// byte count on o_m_tdata. Status continue keeps the file open; complete,
// bad record and header rejected end it, and later words report inactive
// until the next start mark.
// Results are registered. One item is taken every cycle while o_s_tready is
// high; the walk state is a single register updated at each accept.
// The output register is backed by a one-item skid stage, so the input stays
// ready while one finished item waits; o_s_tready drops only when both hold
// items that the receiver has not taken.
// Reset clears the walk state (inactive), empties both output stages and
// loads the register defaults: max_record_bytes 1048576, min_total_bytes 88.
// Registers are written over the APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module emf_record_stream_validator import emf_rsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] data_word
    input  logic        i_s_tuser,   // [0] start_of_file
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [39:0] file_bytes
    output logic [3:0]  o_m_tuser,   // [2:0] status, [3] record_start
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_max_record;
    logic [31:0] r_min_total;
    t_walk_state r_state;
    t_walk_state n_state;
    t_result     step_res;
    t_result     r_out;
    t_result     r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;
    logic        in_acc;
    logic        out_take;
    t_reg_idx    reg_idx;

    emf_rsv_step u_step (
        .i_state      (r_state),
        .i_word       (i_s_tdata),
        .i_sof        (i_s_tuser),
        .i_max_record (r_max_record),
        .i_min_total  (r_min_total),
        .o_state      (n_state),
        .o_result     (step_res)
    );

    assign in_acc   = i_s_tvalid && !r_skid_valid;
    assign out_take = r_out_valid && i_m_tready;
    assign reg_idx  = t_reg_idx'(paddr[2]);

    assign o_s_tready = !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.file_bytes;
    assign o_m_tuser  = {r_out.record_start, r_out.status};
    assign pready     = 1'b1;
    assign prdata     = (reg_idx == REG_MIN_TOTAL) ? r_min_total : r_max_record;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_record <= MAX_RECORD_RESET;
            r_min_total  <= MIN_TOTAL_RESET;
            r_state      <= '{active: 1'b0, word_pos: '0, next_rec: '0,
                              pend_end: 1'b0, hdr_ok: 1'b0};
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                case (reg_idx)
                    REG_MAX_RECORD: r_max_record <= pwdata;
                    REG_MIN_TOTAL:  r_min_total  <= pwdata;
                    default:        r_max_record <= r_max_record;
                endcase
            end

            if (in_acc) begin
                r_state <= n_state;
            end

            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (in_acc) begin
                    r_out       <= step_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (in_acc) begin
                // receiver stalled: park the new item
                r_skid       <= step_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

// ===== hdl/emf_rsv_step.sv =====
// ----------------------------------------------------------------------------
// emf_rsv_step
// Per-word header check and record walk: next state and result for one item.
// ----------------------------------------------------------------------------
module emf_rsv_step import emf_rsv_pkg::*; (
    input  t_walk_state i_state,
    input  logic [31:0] i_word,
    input  logic        i_sof,
    input  logic [31:0] i_max_record,
    input  logic [31:0] i_min_total,
    output t_walk_state o_state,
    output t_result     o_result
);

    t_walk_state          cur;
    logic [WORD_BITS-1:0] pos_inc;
    logic [WORD_BITS:0]   size_pos;
    logic [WORD_BITS:0]   rec_end;
    logic [WORD_BITS-1:0] next_rec_eff;
    logic                 hdr_ok_eff;
    logic                 hdr_reject;
    logic                 size_bad;
    logic [BYTES_BITS-1:0] bytes;

    always_comb begin
        cur = i_state;
        if (i_sof) begin
            cur = '{active: 1'b1, word_pos: '0, next_rec: '0, pend_end: 1'b0, hdr_ok: 1'b0};
        end

        pos_inc = cur.word_pos + WORD_BITS'(1);
        bytes   = {pos_inc, 2'b00};

        hdr_reject = ((cur.word_pos == POS_MAGIC) && (i_word != HDR_MAGIC))
                  || ((cur.word_pos == POS_HDR_SIZE)
                      && ((i_word < HDR_MIN_SIZE) || (i_word[1:0] != 2'b00)))
                  || ((cur.word_pos == POS_SIGNATURE) && (i_word != EMF_SIGNATURE))
                  || ((cur.word_pos == POS_TOTAL) && (i_word < i_min_total))
                  || ((cur.word_pos == POS_RESERVED) && (i_word[31:16] != 16'h0000));

        // header size and reserved check take effect before the walk looks at this word
        next_rec_eff = (cur.word_pos == POS_HDR_SIZE) ? WORD_BITS'(i_word[31:2])
                                                      : cur.next_rec;
        hdr_ok_eff   = (cur.word_pos == POS_RESERVED) ? 1'b1 : cur.hdr_ok;

        size_pos = {1'b0, next_rec_eff} + (WORD_BITS+1)'(1);
        rec_end  = {1'b0, next_rec_eff} + (WORD_BITS+1)'(i_word[31:2]);
        size_bad = (i_word < MIN_REC_SIZE) || (i_word[1:0] != 2'b00)
                || (i_word > i_max_record);

        o_state  = cur;
        o_result = '{record_start: 1'b0, status: ST_CONTINUE, file_bytes: bytes};

        if (!cur.active) begin
            o_result.status     = ST_INACTIVE;
            o_result.file_bytes = '0;
        end else if (cur.word_pos == WORD_MASK) begin
            o_result.status     = ST_BAD_RECORD;
            o_result.file_bytes = LEN_MASK;
        end else if (hdr_reject) begin
            o_result.status = ST_REJECTED;
        end else begin
            o_state.next_rec = next_rec_eff;
            o_state.hdr_ok   = hdr_ok_eff;
            o_state.word_pos = pos_inc;
            if (cur.word_pos >= POS_WALK) begin
                if (cur.word_pos == next_rec_eff) begin
                    o_result.record_start = 1'b1;
                    o_state.pend_end      = (i_word == EOF_TYPE);
                end else if ({1'b0, cur.word_pos} == size_pos) begin
                    if (size_bad) begin
                        o_result.status = ST_BAD_RECORD;
                    end else if (rec_end[WORD_BITS]) begin
                        o_result.status     = ST_BAD_RECORD;
                        o_result.file_bytes = LEN_MASK;
                    end else begin
                        o_state.next_rec = rec_end[WORD_BITS-1:0];
                        if (cur.pend_end && hdr_ok_eff) begin
                            o_result.status     = ST_COMPLETE;
                            o_result.file_bytes = {rec_end[WORD_BITS-1:0], 2'b00};
                        end
                    end
                end
            end
        end

        // any final status ends the file until the next start mark
        if (o_result.status != ST_CONTINUE) begin
            o_state.active = 1'b0;
        end
    end

endmodule
